// ===== rtl/tfdt_pkg.sv =====
// Shared types, constants and the edge-function step table of the fragment depth tester.
package tfdt_pkg;

  localparam int unsigned DefTileWidth  = 64;
  localparam int unsigned DefTileHeight = 64;

  // Datapath widths.
  localparam int unsigned GeoW    = 36;  // edge and barycentric terms
  localparam int unsigned AccW    = 64;  // multiply-accumulate register
  localparam int unsigned DivW    = 64;  // dividend and quotient
  localparam int unsigned DsrW    = 48;  // divisor
  localparam int unsigned MulAW   = 25;
  localparam int unsigned MulBW   = 18;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned WeightW = 17;  // Q1.16 barycentric weight, up to 1.0
  localparam int unsigned RecW    = 41;  // perspective weight
  localparam int unsigned SumW    = 42;  // sum of three perspective weights
  localparam int unsigned HiShift = 24;  // split point of a perspective weight

  localparam logic [1:0]        SlotUnused = 2'd3;
  localparam logic signed [15:0] DepthOne  = 16'sd16384;
  localparam logic [7:0]        GreyLevel  = 8'd25;
  localparam logic [23:0]       WOne       = 24'd256;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SHADE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         vertex_slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] depth_z;
    logic [23:0]        clip_w;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [5:0]         pixel_x;
    logic [5:0]         pixel_y;
  } in_t;

  typedef struct packed {
    logic               covered;
    logic               written;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic signed [15:0] depth_out;
  } out_t;

  typedef struct packed {
    logic signed [15:0] depth;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pix_t;

  typedef struct packed {
    logic                     issue;
    logic                     clear;
    logic                     neg;
    logic                     shift_hi;
    logic signed [MulAW-1:0]  op_a;
    logic signed [MulBW-1:0]  op_b;
  } mac_req_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  // Coordinate sources for the edge-function products.
  typedef enum logic [2:0] {
    CO_X0 = 3'd0,
    CO_X1 = 3'd1,
    CO_X2 = 3'd2,
    CO_PX = 3'd3,
    CO_Y0 = 3'd4,
    CO_Y1 = 3'd5,
    CO_Y2 = 3'd6,
    CO_PY = 3'd7
  } coord_e;

  typedef struct packed {
    coord_e a1;
    coord_e a2;
    coord_e b1;
    coord_e b2;
    logic   neg;
  } geo_op_t;

  localparam logic [3:0] GeoLastStep = 4'd13;

  // Each term is (a1 - a2) * (b1 - b2), added or subtracted. Pairs of steps
  // form e0, e1, e2, na, da, nb, db in that order.
  function automatic geo_op_t geo_op(input logic [3:0] step);
    geo_op_t op;
    case (step)
      4'd0:    op = '{CO_X0, CO_PX, CO_Y0, CO_Y1, 1'b0};
      4'd1:    op = '{CO_Y0, CO_PY, CO_X0, CO_X1, 1'b1};
      4'd2:    op = '{CO_X1, CO_PX, CO_Y1, CO_Y2, 1'b0};
      4'd3:    op = '{CO_Y1, CO_PY, CO_X1, CO_X2, 1'b1};
      4'd4:    op = '{CO_X2, CO_PX, CO_Y2, CO_Y0, 1'b0};
      4'd5:    op = '{CO_Y2, CO_PY, CO_X2, CO_X0, 1'b1};
      4'd6:    op = '{CO_PX, CO_X1, CO_Y2, CO_Y1, 1'b1};
      4'd7:    op = '{CO_PY, CO_Y1, CO_X2, CO_X1, 1'b0};
      4'd8:    op = '{CO_X0, CO_X1, CO_Y2, CO_Y1, 1'b1};
      4'd9:    op = '{CO_Y0, CO_Y1, CO_X2, CO_X1, 1'b0};
      4'd10:   op = '{CO_PX, CO_X2, CO_Y0, CO_Y2, 1'b1};
      4'd11:   op = '{CO_PY, CO_Y2, CO_X0, CO_X2, 1'b0};
      4'd12:   op = '{CO_X1, CO_X2, CO_Y0, CO_Y2, 1'b1};
      4'd13:   op = '{CO_Y1, CO_Y2, CO_X0, CO_X2, 1'b0};
      default: op = '{CO_X0, CO_X0, CO_X0, CO_X0, 1'b0};
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/tfdt_mac.sv =====
// Shared signed multiplier with a registered product and a 64-bit accumulator.
module tfdt_mac
  import tfdt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mac_req_t               req_i,
  output logic signed [AccW-1:0] acc_next_o
);

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  acc_q, term;
  logic                    pend_q, clear_q, neg_q, hi_q;

  assign prod_d = req_i.op_a * req_i.op_b;

  always_comb begin
    term = AccW'(prod_q);
    if (hi_q) begin
      term = term <<< HiShift;
    end
    if (neg_q) begin
      term = -term;
    end
    acc_next_o = (clear_q ? '0 : acc_q) + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= req_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.issue) begin
      prod_q  <= prod_d;
      clear_q <= req_i.clear;
      neg_q   <= req_i.neg;
      hi_q    <= req_i.shift_hi;
    end
    if (pend_q) begin
      acc_q <= acc_next_o;
    end
  end

endmodule

// ===== rtl/tfdt_div.sv =====
// Restoring unsigned divider that retires one quotient bit per cycle.
module tfdt_div
  import tfdt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivW);
  localparam logic [CntW-1:0] CntLast = CntW'(DivW - 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q;
  logic [DsrW-1:0] rem_q, dsr_q;
  logic [DsrW:0]   trial, diff;
  logic            fits;

  assign trial  = {rem_q, quo_q[DivW-1]};
  assign diff   = trial - {1'b0, dsr_q};
  assign fits   = trial >= {1'b0, dsr_q};
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntLast);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DsrW-1:0] : trial[DsrW-1:0];
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

endmodule

// ===== rtl/tfdt_mem.sv =====
// Depth and color buffer memory with a clearing sweep after reset.
module tfdt_mem
  import tfdt_pkg::*;
#(
  parameter int unsigned Depth = DefTileWidth * DefTileHeight,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             clr_busy_o,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output pix_t             rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  pix_t             wr_data_i
);

  localparam logic [AddrW-1:0] AddrLast = AddrW'(Depth - 1);

  pix_t             mem_q [Depth];
  pix_t             rd_q;
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  assign clr_busy_o = clr_busy_q;
  assign rd_data_o  = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AddrLast) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '{DepthOne, GreyLevel, GreyLevel, GreyLevel};
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/triangle_fragment_depth_tester.sv =====
// Load, read and unknown commands go straight to the result state; a shade first runs the
// edge products, and only a pixel that passes the edge test goes on to the divider and
// weight passes; one transaction at a time. For a covered pixel the shade time is set by the
// 64-step divider, used nine times, and by 38 passes through the single shared multiplier.
// After reset the buffers are swept to depth 1.0 and grey 25, one pixel per cycle, over all
// TILE_WIDTH * TILE_HEIGHT pixels (4096 by default), before the first transaction is taken.
module triangle_fragment_depth_tester
  import tfdt_pkg::*;
#(
  parameter int unsigned TILE_WIDTH  = DefTileWidth,
  parameter int unsigned TILE_HEIGHT = DefTileHeight
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned Pixels = TILE_WIDTH * TILE_HEIGHT;
  localparam int unsigned AddrW  = $clog2(Pixels);

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_GEO   = 10'b00_0000_0010,
    S_CHECK = 10'b00_0000_0100,
    S_BARY  = 10'b00_0000_1000,
    S_AFILL = 10'b00_0001_0000,
    S_RECIP = 10'b00_0010_0000,
    S_SUM   = 10'b00_0100_0000,
    S_WMAC  = 10'b00_1000_0000,
    S_ROUND = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  state_e state_q;
  logic [3:0] step_q;
  logic       ph_q;
  logic [1:0] idx_q;
  logic [1:0] ch_q;
  logic       div_wait_q;
  logic       covered_q;
  logic       out_valid_q;

  // Stored triangle corners.
  logic signed [15:0] cx_q [3];
  logic signed [15:0] cy_q [3];
  logic signed [15:0] cz_q [3];
  logic [23:0]        cw_q [3];
  logic [7:0]         cr_q [3];
  logic [7:0]         cg_q [3];
  logic [7:0]         cb_q [3];

  // Per-transaction working registers.
  logic [1:0]              cmd_q;
  logic [5:0]              px_q, py_q;
  logic                    inside_q;
  logic [AddrW-1:0]        addr_q;
  logic signed [GeoW-1:0]  geo_q [7];
  logic [WeightW-1:0]      a_q [3];
  logic [RecW-1:0]         r_q [3];
  logic [SumW-1:0]         s_q;
  logic signed [AccW-1:0]  num_q;
  logic signed [15:0]      z_res_q;
  logic [7:0]              red_q, green_q, blue_q;
  out_t                    out_q;

  logic accept, launch, clr_busy;
  logic in_inside;
  logic [AddrW-1:0] in_addr;

  mac_req_t               mac_req;
  logic signed [AccW-1:0] acc_next;
  div_req_t               div_req;
  logic                   div_done;
  logic [DivW-1:0]        div_quot;

  pix_t mem_rd, mem_wr;
  logic mem_wr_en;

  assign in_ready_o  = (state_q == S_IDLE) && !clr_busy;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign launch      = !out_valid_q || out_ready_i;

  assign in_inside = (32'(in_data_i.pixel_x) < TILE_WIDTH) &&
                     (32'(in_data_i.pixel_y) < TILE_HEIGHT);
  assign in_addr   = in_inside ?
                     AddrW'(32'(in_data_i.pixel_y) * TILE_WIDTH + 32'(in_data_i.pixel_x)) : '0;

  // Coordinate select for the edge products. Pixel centres sit at pixel * 16 + 8 in Q12.4.
  function automatic logic signed [15:0] coord(input coord_e c);
    logic signed [15:0] v;
    case (c)
      CO_X0:   v = cx_q[0];
      CO_X1:   v = cx_q[1];
      CO_X2:   v = cx_q[2];
      CO_PX:   v = {6'b0, px_q, 4'b1000};
      CO_Y0:   v = cy_q[0];
      CO_Y1:   v = cy_q[1];
      CO_Y2:   v = cy_q[2];
      CO_PY:   v = {6'b0, py_q, 4'b1000};
      default: v = '0;
    endcase
    return v;
  endfunction

  geo_op_t            gop;
  logic signed [16:0] gda, gdb;
  logic [1:0]         wc;
  logic [RecW-1:0]    r_sel;

  always_comb begin
    gop   = geo_op(step_q);
    gda   = 17'(coord(gop.a1)) - 17'(coord(gop.a2));
    gdb   = 17'(coord(gop.b1)) - 17'(coord(gop.b2));
    wc    = step_q[2:1];
    r_sel = r_q[wc];

    mac_req = '0;
    if (state_q == S_GEO) begin
      // Even steps start a new sum of two products.
      mac_req.issue = !ph_q;
      mac_req.clear = !step_q[0];
      mac_req.neg   = gop.neg;
      mac_req.op_a  = MulAW'(gda);
      mac_req.op_b  = MulBW'(gdb);
    end else if (state_q == S_WMAC) begin
      // Each perspective weight goes through the multiplier in two halves.
      mac_req.issue    = !ph_q;
      mac_req.clear    = (step_q == 4'd0);
      mac_req.shift_hi = step_q[0];
      mac_req.op_a     = step_q[0] ? MulAW'(r_sel[RecW-1:HiShift]) :
                                     MulAW'(r_sel[HiShift-1:0]);
      case (ch_q)
        2'd0:    mac_req.op_b = MulBW'(cz_q[wc]);
        2'd1:    mac_req.op_b = MulBW'(cr_q[wc]);
        2'd2:    mac_req.op_b = MulBW'(cg_q[wc]);
        default: mac_req.op_b = MulBW'(cb_q[wc]);
      endcase
    end
  end

  tfdt_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mac_req),
    .acc_next_o (acc_next)
  );

  // Barycentric operands: make the denominator positive, clamp the numerator into 0..d.
  logic signed [GeoW-1:0] bn, bd, bnn, bdd, bnc;
  logic [23:0]            w_sel;
  logic [AccW-1:0]        num_mag;

  always_comb begin
    bn = idx_q[0] ? geo_q[5] : geo_q[3];
    bd = idx_q[0] ? geo_q[6] : geo_q[4];
    if (bd < 0) begin
      bnn = -bn;
      bdd = -bd;
    end else begin
      bnn = bn;
      bdd = bd;
    end
    if (bnn < 0) begin
      bnc = '0;
    end else if (bnn > bdd) begin
      bnc = bdd;
    end else begin
      bnc = bnn;
    end
    w_sel   = cw_q[idx_q];
    num_mag = num_q[AccW-1] ? AccW'(-num_q) : AccW'(num_q);

    div_req.start = ((state_q == S_BARY) || (state_q == S_RECIP) ||
                     (state_q == S_ROUND)) && !div_wait_q;
    case (state_q)
      S_BARY: begin
        div_req.dividend = {12'b0, bnc, 16'b0};
        div_req.divisor  = {12'b0, bdd};
      end
      S_RECIP: begin
        div_req.dividend = {23'b0, a_q[idx_q], 24'b0};
        div_req.divisor  = {24'b0, (w_sel == '0) ? 24'd1 : w_sel};
      end
      default: begin
        // Round half away from zero: add half the weight sum to the magnitude.
        div_req.dividend = num_mag + DivW'(s_q >> 1);
        div_req.divisor  = DsrW'(s_q);
      end
    endcase
  end

  tfdt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Remaining arithmetic between divider passes.
  logic signed [18:0]  a2s;
  logic [SumW-1:0]     s_sum;
  logic                geo_hit;
  logic [15:0]         rz;
  logic [7:0]          rc;

  always_comb begin
    a2s   = 19'sd65536 - 19'(a_q[0]) - 19'(a_q[1]);
    s_sum = SumW'(r_q[0]) + SumW'(r_q[1]) + SumW'(r_q[2]);
    // Strictly negative edges only, so one winding is covered.
    geo_hit = (geo_q[0] < 0) && (geo_q[1] < 0) && (geo_q[2] < 0) &&
              (geo_q[4] != 0) && (geo_q[6] != 0);
    if (num_q[AccW-1]) begin
      rz = (div_quot > 64'd32768) ? 16'h8000 : -div_quot[15:0];
      rc = 8'd0;
    end else begin
      rz = (div_quot > 64'd32767) ? 16'h7FFF : div_quot[15:0];
      rc = (div_quot > 64'd255) ? 8'hFF : div_quot[7:0];
    end
  end

  // Result and buffer update when the transaction completes.
  out_t res;
  logic wr_hit;

  always_comb begin
    res    = '0;
    wr_hit = mem_rd.depth > z_res_q;
    if ((cmd_q == CMD_SHADE) && covered_q) begin
      res.covered   = 1'b1;
      res.written   = inside_q && wr_hit;
      res.red_out   = red_q;
      res.green_out = green_q;
      res.blue_out  = blue_q;
      res.depth_out = z_res_q;
    end else if ((cmd_q == CMD_READ) && inside_q) begin
      res.red_out   = mem_rd.red;
      res.green_out = mem_rd.green;
      res.blue_out  = mem_rd.blue;
      res.depth_out = mem_rd.depth;
    end
    mem_wr_en = (state_q == S_DONE) && launch && res.written;
    mem_wr    = '{z_res_q, red_q, green_q, blue_q};
  end

  // The buffer read is issued on acceptance of every transaction; the registered
  // data holds until the next transaction is taken.
  tfdt_mem #(
    .Depth (Pixels),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_busy_o (clr_busy),
    .rd_en_i    (accept),
    .rd_addr_i  (in_addr),
    .rd_data_o  (mem_rd),
    .wr_en_i    (mem_wr_en),
    .wr_addr_i  (addr_q),
    .wr_data_i  (mem_wr)
  );

  // Sequencer and corner registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      ph_q        <= 1'b0;
      idx_q       <= '0;
      ch_q        <= '0;
      div_wait_q  <= 1'b0;
      covered_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cx_q[i] <= '0;
        cy_q[i] <= '0;
        cz_q[i] <= '0;
        cw_q[i] <= WOne;
        cr_q[i] <= '0;
        cg_q[i] <= '0;
        cb_q[i] <= '0;
      end
    end else begin
      // A new result is presented as the old one leaves, or into an empty slot.
      if ((state_q == S_DONE) && launch) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            covered_q <= 1'b0;
            step_q    <= '0;
            ph_q      <= 1'b0;
            if ((in_data_i.command == CMD_LOAD) && (in_data_i.vertex_slot != SlotUnused)) begin
              cx_q[in_data_i.vertex_slot] <= in_data_i.pos_x;
              cy_q[in_data_i.vertex_slot] <= in_data_i.pos_y;
              cz_q[in_data_i.vertex_slot] <= in_data_i.depth_z;
              cw_q[in_data_i.vertex_slot] <= in_data_i.clip_w;
              cr_q[in_data_i.vertex_slot] <= in_data_i.red_in;
              cg_q[in_data_i.vertex_slot] <= in_data_i.green_in;
              cb_q[in_data_i.vertex_slot] <= in_data_i.blue_in;
            end
            state_q <= (in_data_i.command == CMD_SHADE) ? S_GEO : S_DONE;
          end
        end
        S_GEO: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (step_q == GeoLastStep) begin
              state_q <= S_CHECK;
            end else begin
              step_q <= step_q + 1'b1;
            end
          end
        end
        S_CHECK: begin
          idx_q   <= '0;
          state_q <= geo_hit ? S_BARY : S_DONE;
        end
        S_BARY: begin
          if (!div_wait_q) begin
            div_wait_q <= 1'b1;
          end else if (div_done) begin
            div_wait_q <= 1'b0;
            if (idx_q[0]) begin
              state_q <= S_AFILL;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_AFILL: begin
          idx_q   <= '0;
          state_q <= S_RECIP;
        end
        S_RECIP: begin
          if (!div_wait_q) begin
            div_wait_q <= 1'b1;
          end else if (div_done) begin
            div_wait_q <= 1'b0;
            if (idx_q == 2'd2) begin
              state_q <= S_SUM;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_SUM: begin
          ch_q    <= '0;
          step_q  <= '0;
          ph_q    <= 1'b0;
          state_q <= (s_sum == '0) ? S_DONE : S_WMAC;
        end
        S_WMAC: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (step_q == 4'd5) begin
              state_q <= S_ROUND;
            end else begin
              step_q <= step_q + 1'b1;
            end
          end
        end
        S_ROUND: begin
          if (!div_wait_q) begin
            div_wait_q <= 1'b1;
          end else if (div_done) begin
            div_wait_q <= 1'b0;
            step_q     <= '0;
            ph_q       <= 1'b0;
            if (ch_q == 2'd3) begin
              covered_q <= 1'b1;
              state_q   <= S_DONE;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= S_WMAC;
            end
          end
        end
        S_DONE: begin
          if (launch) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_data_i.command;
      px_q     <= in_data_i.pixel_x;
      py_q     <= in_data_i.pixel_y;
      inside_q <= in_inside;
      addr_q   <= in_addr;
    end
    if ((state_q == S_GEO) && ph_q && step_q[0]) begin
      geo_q[step_q[3:1]] <= acc_next[GeoW-1:0];
    end
    if ((state_q == S_BARY) && div_wait_q && div_done) begin
      a_q[idx_q] <= div_quot[WeightW-1:0];
    end
    if (state_q == S_AFILL) begin
      a_q[2] <= a2s[18] ? '0 : a2s[WeightW-1:0];
    end
    if ((state_q == S_RECIP) && div_wait_q && div_done) begin
      r_q[idx_q] <= div_quot[RecW-1:0];
    end
    if (state_q == S_SUM) begin
      s_q <= s_sum;
    end
    if ((state_q == S_WMAC) && ph_q && (step_q == 4'd5)) begin
      num_q <= acc_next;
    end
    if ((state_q == S_ROUND) && div_wait_q && div_done) begin
      case (ch_q)
        2'd0:    z_res_q <= rz;
        2'd1:    red_q   <= rc;
        2'd2:    green_q <= rc;
        default: blue_q  <= rc;
      endcase
    end
    if ((state_q == S_DONE) && launch) begin
      out_q <= res;
    end
  end

endmodule

// ===== tb/tb_triangle_fragment_depth_tester.sv =====
// Self-checking testbench for the triangle fragment depth tester: directed table, then random scenes.
module tb_triangle_fragment_depth_tester;
  import tfdt_pkg::*;

  // Command code that the block must treat as a no-op.
  localparam logic [1:0] CmdUnknown = 2'd3;
  // Cycles without any handshake before the run is declared hung. This covers the
  // post-reset buffer sweep, the slowest covered shade and the longest stalls.
  localparam int unsigned HangLimit = 30000;
  localparam int unsigned NumRandom = 1050;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  triangle_fragment_depth_tester uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the triangle corners and of both pixel buffers.
  logic signed [15:0] corner_px_x [3];
  logic signed [15:0] corner_px_y [3];
  logic signed [15:0] corner_z    [3];
  logic [23:0]        corner_wq   [3];
  logic [23:0]        corner_rgb  [3];
  logic signed [15:0] zbuf        [4096];
  logic [23:0]        rgbbuf      [4096];

  // A row of the directed table: the transaction, and optionally a typed-in result.
  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  out_t result_q [$];   // results still owed by the block
  int   errors = 0;
  int   shades_hit = 0;
  int   pixels_written = 0;
  int   reads_done = 0;
  int   idle_cycles = 0;
  bit   next_typed = 1'b0;
  out_t next_want = '0;

  initial begin
    for (int i = 0; i < 3; i++) begin
      corner_px_x[i] = '0;
      corner_px_y[i] = '0;
      corner_z[i]    = '0;
      corner_wq[i]   = WOne;
      corner_rgb[i]  = '0;
    end
    for (int i = 0; i < 4096; i++) begin
      zbuf[i]   = DepthOne;
      rgbbuf[i] = {GreyLevel, GreyLevel, GreyLevel};
    end
  end

  // Barycentric weight in Q1.16, with the sign of the denominator folded out.
  function automatic longint bary_weight(longint n, longint d);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n < 0) n = 0;
    if (n > d) n = d;
    return (n * 65536) / d;
  endfunction

  // Division rounded to nearest, halves away from zero; den is positive.
  function automatic longint div_nearest(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -(((-num) + den / 2) / den);
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Works out the result of one transaction and applies its effect on the shadow state.
  function automatic out_t fragment_result(in_t it);
    out_t   res;
    int     idx;
    longint px, py, xa, ya, xb, yb, xc, yc;
    longint e0, e1, e2, na, da, nb, db, s, zn, zp, wv;
    longint wt [3];
    longint rw [3];
    longint ch [3];
    res = '0;
    idx = int'({it.pixel_y, it.pixel_x});
    case (it.command)
      CMD_LOAD: begin
        if (it.vertex_slot != SlotUnused) begin
          corner_px_x[it.vertex_slot] = it.pos_x;
          corner_px_y[it.vertex_slot] = it.pos_y;
          corner_z[it.vertex_slot]    = it.depth_z;
          corner_wq[it.vertex_slot]   = it.clip_w;
          corner_rgb[it.vertex_slot]  = {it.red_in, it.green_in, it.blue_in};
        end
      end
      CMD_READ: begin
        res.red_out   = rgbbuf[idx][23:16];
        res.green_out = rgbbuf[idx][15:8];
        res.blue_out  = rgbbuf[idx][7:0];
        res.depth_out = zbuf[idx];
      end
      CMD_SHADE: begin
        px = longint'(it.pixel_x) * 16 + 8;
        py = longint'(it.pixel_y) * 16 + 8;
        xa = corner_px_x[0]; ya = corner_px_y[0];
        xb = corner_px_x[1]; yb = corner_px_y[1];
        xc = corner_px_x[2]; yc = corner_px_y[2];
        e0 = (xa - px) * (ya - yb) - (ya - py) * (xa - xb);
        e1 = (xb - px) * (yb - yc) - (yb - py) * (xb - xc);
        e2 = (xc - px) * (yc - ya) - (yc - py) * (xc - xa);
        na = -(px - xb) * (yc - yb) + (py - yb) * (xc - xb);
        da = -(xa - xb) * (yc - yb) + (ya - yb) * (xc - xb);
        nb = -(px - xc) * (ya - yc) + (py - yc) * (xa - xc);
        db = -(xb - xc) * (ya - yc) + (yb - yc) * (xa - xc);
        if (e0 < 0 && e1 < 0 && e2 < 0 && da != 0 && db != 0) begin
          wt[0] = bary_weight(na, da);
          wt[1] = bary_weight(nb, db);
          wt[2] = 65536 - wt[0] - wt[1];
          if (wt[2] < 0) wt[2] = 0;
          s = 0;
          for (int i = 0; i < 3; i++) begin
            // A stored w of zero is taken as one.
            wv = (corner_wq[i] == 0) ? 1 : longint'(corner_wq[i]);
            rw[i] = (wt[i] <<< 24) / wv;
            s += rw[i];
          end
          if (s > 0) begin
            zn = 0;
            for (int k = 0; k < 3; k++) ch[k] = 0;
            for (int i = 0; i < 3; i++) begin
              zn += rw[i] * longint'(corner_z[i]);
              for (int k = 0; k < 3; k++)
                ch[k] += rw[i] * longint'(corner_rgb[i][23 - 8 * k -: 8]);
            end
            zp = clamp_to(div_nearest(zn, s), -32768, 32767);
            for (int k = 0; k < 3; k++) ch[k] = clamp_to(div_nearest(ch[k], s), 0, 255);
            res.covered   = 1'b1;
            res.red_out   = ch[0][7:0];
            res.green_out = ch[1][7:0];
            res.blue_out  = ch[2][7:0];
            res.depth_out = zp[15:0];
            // Depth test: only a strictly nearer fragment replaces the stored one.
            if (longint'(zbuf[idx]) > zp) begin
              zbuf[idx]   = zp[15:0];
              rgbbuf[idx] = {ch[0][7:0], ch[1][7:0], ch[2][7:0]};
              res.written = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_t vertex_load(logic [1:0] slot, int x, int y, int z, int w,
                                      int r, int g, int b);
    in_t it;
    it = '0;
    it.command     = CMD_LOAD;
    it.vertex_slot = slot;
    it.pos_x       = x[15:0];
    it.pos_y       = y[15:0];
    it.depth_z     = z[15:0];
    it.clip_w      = w[23:0];
    it.red_in      = r[7:0];
    it.green_in    = g[7:0];
    it.blue_in     = b[7:0];
    return it;
  endfunction

  function automatic in_t pixel_cmd(logic [1:0] cmd, int x, int y);
    in_t it;
    it = '0;
    it.command = cmd;
    it.pixel_x = x[5:0];
    it.pixel_y = y[5:0];
    return it;
  endfunction

  function automatic row_t row(in_t it, bit typed = 1'b0, out_t want = '0);
    row_t r;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic compare_result(out_t want, out_t got);
    if (want.covered !== got.covered) begin
      $display("%0t covered: expected %0d, got %0d", $time, want.covered, got.covered);
      errors++;
    end
    if (want.written !== got.written) begin
      $display("%0t written: expected %0d, got %0d", $time, want.written, got.written);
      errors++;
    end
    if (want.red_out !== got.red_out) begin
      $display("%0t red_out: expected %0d, got %0d", $time, want.red_out, got.red_out);
      errors++;
    end
    if (want.green_out !== got.green_out) begin
      $display("%0t green_out: expected %0d, got %0d", $time, want.green_out, got.green_out);
      errors++;
    end
    if (want.blue_out !== got.blue_out) begin
      $display("%0t blue_out: expected %0d, got %0d", $time, want.blue_out, got.blue_out);
      errors++;
    end
    if (want.depth_out !== got.depth_out) begin
      $display("%0t depth_out: expected %0d, got %0d", $time, want.depth_out, got.depth_out);
      errors++;
    end
  endtask

  // Scoreboard. Input transactions are predicted as they are accepted; output
  // transactions are matched against the oldest prediction. The watchdog counts
  // cycles in which neither side completes a handshake.
  always @(posedge clk_i) begin
    out_t pred;
    if (in_valid_i && in_ready_o) begin
      pred = fragment_result(in_data_i);
      // Directed rows with a typed-in answer are checked against that answer.
      result_q.insert(result_q.size(), next_typed ? next_want : pred);
      if (in_data_i.command == CMD_SHADE && pred.covered) shades_hit++;
      if (pred.written) pixels_written++;
      if (in_data_i.command == CMD_READ) reads_done++;
    end
    if (out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected result: expected none, got %h", $time, out_data_o);
        errors++;
      end else begin
        compare_result(result_q.pop_front(), out_data_o);
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HangLimit) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, HangLimit);
      $display("triangle_fragment_depth_tester: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver moves between phases of steady readiness and phases of heavy stalling.
  int ready_phase_left = 0;
  int ready_percent = 100;
  always @(posedge clk_i) begin
    if (ready_phase_left == 0) begin
      ready_phase_left = $urandom_range(200, 5);
      case ($urandom_range(2))
        0:       ready_percent = 100;
        1:       ready_percent = 60;
        default: ready_percent = 20;
      endcase
    end
    ready_phase_left--;
    out_ready_i <= ($urandom_range(99) < ready_percent);
  end

  // The sender works in bursts; between bursts valid usually drops for a random gap.
  int burst_left = 0;
  task automatic send(row_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      if ($urandom_range(3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_data_i  <= r.item;
    in_valid_i <= 1'b1;
    next_typed <= r.typed;
    next_want  <= r.want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  row_t  directed [$];
  out_t  fresh;
  int    sent;
  int    vx [3];
  int    vy [3];
  int    tmp, x_lo, x_hi, y_lo, y_hi;
  longint orient;

  // Appends one row to the end of the directed table.
  task automatic add_row(row_t r);
    directed.insert(directed.size(), r);
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fresh = '{1'b0, 1'b0, GreyLevel, GreyLevel, GreyLevel, DepthOne};
    // Freshly cleared buffers, a degenerate all-zero triangle, and the no-op commands.
    add_row(row(pixel_cmd(CMD_READ, 0, 0), 1'b1, fresh));
    add_row(row(pixel_cmd(CMD_READ, 63, 63), 1'b1, fresh));
    add_row(row(pixel_cmd(CMD_SHADE, 5, 5), 1'b1, '0));
    add_row(row(vertex_load(SlotUnused, 32767, 32767, 32767, 16777215,
                            255, 255, 255), 1'b1, '0));
    add_row(row(pixel_cmd(CmdUnknown, 63, 63), 1'b1, '0));
    // A triangle over the upper-left half of the tile, wound so that it is covered.
    add_row(row(vertex_load(2'd0, 0, 0, 8192, 256, 255, 0, 0), 1'b1, '0));
    add_row(row(vertex_load(2'd1, 1024, 0, 4096, 512, 0, 255, 0), 1'b1, '0));
    add_row(row(vertex_load(2'd2, 0, 1024, 12288, 1024, 0, 0, 255), 1'b1, '0));
    add_row(row(pixel_cmd(CMD_SHADE, 2, 2)));
    add_row(row(pixel_cmd(CMD_SHADE, 0, 0)));
    add_row(row(pixel_cmd(CMD_SHADE, 0, 0)));
    add_row(row(pixel_cmd(CMD_READ, 0, 0)));
    add_row(row(pixel_cmd(CMD_SHADE, 60, 60), 1'b1, '0));
    // Extreme positions, depths, w values (zero among them) and colours.
    add_row(row(vertex_load(2'd0, -32768, -32768, -32768, 0, 255, 0, 0), 1'b1, '0));
    add_row(row(vertex_load(2'd1, 32767, -32768, 32767, 16777215, 0, 255, 0),
                1'b1, '0));
    add_row(row(vertex_load(2'd2, -32768, 32767, 0, 1, 0, 0, 255), 1'b1, '0));
    add_row(row(pixel_cmd(CMD_SHADE, 10, 10)));
    add_row(row(pixel_cmd(CMD_SHADE, 63, 63)));
    add_row(row(pixel_cmd(CMD_SHADE, 0, 63)));
    add_row(row(pixel_cmd(CMD_READ, 10, 10)));
    // Same corners in the opposite winding are never covered.
    add_row(row(vertex_load(2'd1, -32768, 32767, 0, 1, 0, 0, 255), 1'b1, '0));
    add_row(row(vertex_load(2'd2, 32767, -32768, 32767, 16777215, 0, 255, 0),
                1'b1, '0));
    add_row(row(pixel_cmd(CMD_SHADE, 10, 10), 1'b1, '0));
    foreach (directed[i]) send(directed[i]);

    // Random scenes: a triangle, mostly properly wound, shades inside its bounding box,
    // read-backs, and a sprinkling of noise and broken loads.
    sent = 0;
    while (sent < NumRandom) begin
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(9) == 0) begin
          vx[i] = $signed($urandom_range(65535)) - 32768;
          vy[i] = $signed($urandom_range(65535)) - 32768;
        end else begin
          vx[i] = $urandom_range(1300) - 200;
          vy[i] = $urandom_range(1300) - 200;
        end
      end
      orient = longint'(vx[0] - vx[2]) * (vy[0] - vy[1]) -
               longint'(vy[0] - vy[2]) * (vx[0] - vx[1]);
      if (orient > 0 && $urandom_range(9) != 0) begin
        tmp = vx[1]; vx[1] = vx[2]; vx[2] = tmp;
        tmp = vy[1]; vy[1] = vy[2]; vy[2] = tmp;
      end
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(9))
          0:       tmp = $urandom_range(16777215);
          1:       tmp = 0;
          default: tmp = $urandom_range(4096, 32);
        endcase
        send(row(vertex_load(i[1:0], vx[i], vy[i], $urandom_range(65535), tmp,
                             $urandom_range(255), $urandom_range(255), $urandom_range(255))));
        sent++;
      end
      x_lo = int'(clamp_to(((vx[0] < vx[1] ? vx[0] : vx[1]) < vx[2] ?
                            (vx[0] < vx[1] ? vx[0] : vx[1]) : vx[2]) / 16, 0, 63));
      x_hi = int'(clamp_to(((vx[0] > vx[1] ? vx[0] : vx[1]) > vx[2] ?
                            (vx[0] > vx[1] ? vx[0] : vx[1]) : vx[2]) / 16, 0, 63));
      y_lo = int'(clamp_to(((vy[0] < vy[1] ? vy[0] : vy[1]) < vy[2] ?
                            (vy[0] < vy[1] ? vy[0] : vy[1]) : vy[2]) / 16, 0, 63));
      y_hi = int'(clamp_to(((vy[0] > vy[1] ? vy[0] : vy[1]) > vy[2] ?
                            (vy[0] > vy[1] ? vy[0] : vy[1]) : vy[2]) / 16, 0, 63));
      if (x_lo > x_hi) x_lo = x_hi;
      if (y_lo > y_hi) y_lo = y_hi;
      repeat ($urandom_range(8, 3)) begin
        case ($urandom_range(9))
          0:       send(row(pixel_cmd(CMD_READ, $urandom_range(x_hi, x_lo),
                                      $urandom_range(y_hi, y_lo))));
          1:       send(row(in_t'(($bits(in_t))'({$urandom, $urandom, $urandom,
                                                  $urandom}))));
          2:       send(row(vertex_load(SlotUnused, $urandom_range(65535),
                                        $urandom_range(65535), $urandom_range(65535),
                                        $urandom_range(16777215), $urandom_range(255),
                                        $urandom_range(255), $urandom_range(255))));
          default: send(row(pixel_cmd(CMD_SHADE, $urandom_range(x_hi, x_lo),
                                      $urandom_range(y_hi, y_lo))));
        endcase
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Ran %0d directed and %0d random transactions: %0d covered shades,",
             directed.size(), sent, shades_hit);
    $display("%0d buffer writes and %0d read-backs, %0d field mismatches.",
             pixels_written, reads_done, errors);
    if (errors == 0) begin
      $display("triangle_fragment_depth_tester: match");
    end else begin
      $display("triangle_fragment_depth_tester: mismatch");
    end
    $finish;
  end

endmodule
